[design/assert_macros.svh]
// Assertion macros used by the interleaved index scatter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property that is switched off while reset is held.
`define IIS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");

// Checked property that is also evaluated while reset is held.
`define IIS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

[design/iis_pkg.sv]
// Shared constants, width helper and status type for the interleaved index scatter core.
package iis_pkg;

    // Defaults for the top-level parameters.
    localparam int IIS_INDEX_WIDTH     = 32;
    localparam int IIS_MAX_GROUP_COUNT = 65536;
    localparam int IIS_MAX_GROUP_SIZE  = 1024;

    // Depth of the queue between the front and back ends.
    localparam int IIS_QUEUE_DEPTH = 4;

    // Fixed field widths of the external channels.
    localparam int IIS_VALUE_W = 32;
    localparam int IIS_COUNT_IN_W = 17;
    localparam int IIS_SIZE_IN_W = 11;

    // Bits needed to hold the values 0 .. n-1, never fewer than one.
    function automatic int iis_width(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

    // Fill status reported by the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } iis_q_status_t;

endpackage

[design/iis_queue.sv]
// Small register-based FIFO that decouples the front end from the back end.
module iis_queue
    import iis_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = IIS_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data,
    output iis_q_status_t     status
);

    localparam int AW = iis_width(DEPTH);
    localparam int LW = iis_width(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]     level_reg, level_next;
    logic              push, pop;

    // Status flags follow directly from the fill level.
    assign status.full  = (level_reg == LW'(DEPTH));
    assign status.empty = (level_reg == '0);

    assign in_ready  = !status.full;
    assign out_valid = !status.empty;
    assign out_data  = mem[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Pointer and level updates, with wrap at the last entry.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            level_next = level_reg + LW'(1);
        end else if (pop && !push) begin
            level_next = level_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage is written on every pushed beat.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[design/iis_front.sv]
// Front end: limits count and size, tracks group and element counters, forms the products.
module iis_front
    import iis_pkg::*;
#(
    parameter int INDEX_WIDTH     = IIS_INDEX_WIDTH,
    parameter int MAX_GROUP_COUNT = IIS_MAX_GROUP_COUNT,
    parameter int MAX_GROUP_SIZE  = IIS_MAX_GROUP_SIZE,
    localparam int GRP_W = iis_width(MAX_GROUP_COUNT)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [IIS_VALUE_W-1:0]    s_row_value,
    input  logic [IIS_COUNT_IN_W-1:0] s_group_count,
    input  logic [IIS_SIZE_IN_W-1:0]  s_group_size,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [IIS_VALUE_W-1:0]    out_value,
    output logic [GRP_W-1:0]          out_grp,
    output logic [INDEX_WIDTH-1:0]    out_ec,
    output logic [INDEX_WIDTH-1:0]    out_cs,
    output logic                      out_seg_end
);

    localparam int IW     = INDEX_WIDTH;
    localparam int ELEM_W = iis_width(MAX_GROUP_SIZE);
    localparam int CNT_W  = iis_width(MAX_GROUP_COUNT + 1);
    localparam int SIZE_W = iis_width(MAX_GROUP_SIZE + 1);
    localparam int EC_W   = ELEM_W + CNT_W;
    localparam int CS_W   = CNT_W + SIZE_W;

    // Counter state carried from one item to the next.
    logic [GRP_W-1:0]  grp_reg, grp_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;

    logic [CNT_W-1:0]  cnt_c, cnt_m1;
    logic [SIZE_W-1:0] size_c, size_m1;
    logic [GRP_W-1:0]  grp_eff;
    logic [ELEM_W-1:0] elem_eff;
    logic              grp_last, elem_last, seg_end;

    // First stage registers.
    logic                   s1_valid_reg, s1_valid_next;
    logic [IIS_VALUE_W-1:0] s1_value_reg;
    logic [GRP_W-1:0]       s1_grp_reg;
    logic [ELEM_W-1:0]      s1_elem_reg;
    logic [CNT_W-1:0]       s1_cnt_reg;
    logic [SIZE_W-1:0]      s1_size_reg;
    logic                   s1_seg_end_reg;

    // Second stage registers.
    logic                   s2_valid_reg, s2_valid_next;
    logic [IIS_VALUE_W-1:0] s2_value_reg;
    logic [GRP_W-1:0]       s2_grp_reg;
    logic [IW-1:0]          s2_ec_reg;
    logic [IW-1:0]          s2_cs_reg;
    logic                   s2_seg_end_reg;

    logic            s1_adv, s2_take;
    logic [EC_W-1:0] ec_full;
    logic [CS_W-1:0] cs_full;

    // Handshake through the two stages.
    assign s2_take = !s2_valid_reg || out_ready;
    assign s_ready = !s1_valid_reg || s2_take;
    assign s1_adv  = s_valid && s_ready;

    // Zero is taken as one and values above the maximum are saturated.
    always_comb begin
        if (s_group_count == '0) begin
            cnt_c = CNT_W'(1);
        end else if (32'(s_group_count) > 32'(MAX_GROUP_COUNT)) begin
            cnt_c = CNT_W'(MAX_GROUP_COUNT);
        end else begin
            cnt_c = CNT_W'(s_group_count);
        end
        if (s_group_size == '0) begin
            size_c = SIZE_W'(1);
        end else if (32'(s_group_size) > 32'(MAX_GROUP_SIZE)) begin
            size_c = SIZE_W'(MAX_GROUP_SIZE);
        end else begin
            size_c = SIZE_W'(s_group_size);
        end
    end

    // Counters past their last position are held at it.
    always_comb begin
        cnt_m1  = cnt_c - CNT_W'(1);
        size_m1 = size_c - SIZE_W'(1);
        grp_eff  = (CNT_W'(grp_reg) > cnt_m1) ? GRP_W'(cnt_m1) : grp_reg;
        elem_eff = (SIZE_W'(elem_reg) > size_m1) ? ELEM_W'(size_m1) : elem_reg;
        grp_last  = (CNT_W'(grp_eff) == cnt_m1);
        elem_last = (SIZE_W'(elem_eff) == size_m1);
        seg_end   = grp_last && elem_last;
    end

    // Advance within a group, then to the next group, then to the next segment.
    always_comb begin
        grp_next  = grp_reg;
        elem_next = elem_reg;
        if (s1_adv) begin
            if (seg_end) begin
                grp_next  = '0;
                elem_next = '0;
            end else if (elem_last) begin
                grp_next  = grp_eff + GRP_W'(1);
                elem_next = '0;
            end else begin
                grp_next  = grp_eff;
                elem_next = elem_eff + ELEM_W'(1);
            end
        end
    end

    always_comb begin
        if (s1_adv) begin
            s1_valid_next = 1'b1;
        end else if (s2_take) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_valid_reg && s2_take) begin
            s2_valid_next = 1'b1;
        end else if (out_ready) begin
            s2_valid_next = 1'b0;
        end else begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg      <= '0;
            elem_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            grp_reg      <= grp_next;
            elem_reg     <= elem_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // First stage captures the resolved position of the beat.
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s1_value_reg   <= s_row_value;
            s1_grp_reg     <= grp_eff;
            s1_elem_reg    <= elem_eff;
            s1_cnt_reg     <= cnt_c;
            s1_size_reg    <= size_c;
            s1_seg_end_reg <= seg_end;
        end
    end

    // Element offset and segment length, reduced to the index width.
    assign ec_full = EC_W'(s1_elem_reg) * EC_W'(s1_cnt_reg);
    assign cs_full = CS_W'(s1_cnt_reg) * CS_W'(s1_size_reg);

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_take) begin
            s2_value_reg   <= s1_value_reg;
            s2_grp_reg     <= s1_grp_reg;
            s2_ec_reg      <= IW'(ec_full);
            s2_cs_reg      <= IW'(cs_full);
            s2_seg_end_reg <= s1_seg_end_reg;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign out_value   = s2_value_reg;
    assign out_grp     = s2_grp_reg;
    assign out_ec      = s2_ec_reg;
    assign out_cs      = s2_cs_reg;
    assign out_seg_end = s2_seg_end_reg;

endmodule

[design/iis_back.sv]
// Back end: accumulates the segment base and holds the result register.
module iis_back
    import iis_pkg::*;
#(
    parameter int INDEX_WIDTH = IIS_INDEX_WIDTH,
    parameter int GRP_W       = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [IIS_VALUE_W-1:0] in_value,
    input  logic [GRP_W-1:0]       in_grp,
    input  logic [INDEX_WIDTH-1:0] in_ec,
    input  logic [INDEX_WIDTH-1:0] in_cs,
    input  logic                   in_seg_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_dest_position,
    output logic [IIS_VALUE_W-1:0] m_moved_value,
    output logic                   m_segment_end
);

    localparam int IW = INDEX_WIDTH;

    logic [IW-1:0]          base_reg, base_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            dest_reg;
    logic [IIS_VALUE_W-1:0] value_reg;
    logic                   seg_end_reg;
    logic                   pop;
    logic [IW-1:0]          dest_sum;

    // A new beat is taken whenever the result register is free or draining.
    assign in_ready = !out_valid_reg || m_ready;
    assign pop      = in_valid && in_ready;

    // Destination and next base, both modulo the index width.
    assign dest_sum  = base_reg + IW'(in_grp) + in_ec;
    assign base_next = (pop && in_seg_end) ? base_reg + in_cs : base_reg;

    always_comb begin
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            dest_reg    <= 32'(dest_sum);
            value_reg   <= in_value;
            seg_end_reg <= in_seg_end;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_dest_position = dest_reg;
    assign m_moved_value   = value_reg;
    assign m_segment_end   = seg_end_reg;

endmodule

[design/interleaved_index_scatter_core.sv]
// Top level of the interleaved index scatter core.
//
// Channel   Direction  Beat contents
// s_        in         row_value, group_count, group_size
// m_        out        dest_position, moved_value, segment_end
//
// One beat is taken every cycle while m_ is not stalled; a result passes the front-end
// stages, the queue and the result register in turn. The rate is set by the counter update
// in the front end and the base accumulation in the back end.
// Reset clears the counters, the segment base and all valid flags.
// A stall on m_ fills the result register, the queue and the front-end stages before s_ready drops.
`include "assert_macros.svh"

module interleaved_index_scatter_core
    import iis_pkg::*;
#(
    parameter int INDEX_WIDTH     = IIS_INDEX_WIDTH,
    parameter int MAX_GROUP_COUNT = IIS_MAX_GROUP_COUNT,
    parameter int MAX_GROUP_SIZE  = IIS_MAX_GROUP_SIZE
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [IIS_VALUE_W-1:0]    s_row_value,
    input  logic [IIS_COUNT_IN_W-1:0] s_group_count,
    input  logic [IIS_SIZE_IN_W-1:0]  s_group_size,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [31:0]               m_dest_position,
    output logic [IIS_VALUE_W-1:0]    m_moved_value,
    output logic                      m_segment_end
);

    localparam int IW    = INDEX_WIDTH;
    localparam int GRP_W = iis_width(MAX_GROUP_COUNT);
    localparam int ENT_W = IIS_VALUE_W + GRP_W + 2 * IW + 1;

    logic                   f_valid, f_ready;
    logic [IIS_VALUE_W-1:0] f_value;
    logic [GRP_W-1:0]       f_grp;
    logic [IW-1:0]          f_ec, f_cs;
    logic                   f_seg_end;
    logic [ENT_W-1:0]       q_in, q_out;
    logic                   q_valid, q_ready;
    iis_q_status_t          q_stat;

    // Front end: counters and products.
    iis_front #(
        .INDEX_WIDTH    (INDEX_WIDTH),
        .MAX_GROUP_COUNT(MAX_GROUP_COUNT),
        .MAX_GROUP_SIZE (MAX_GROUP_SIZE)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_row_value  (s_row_value),
        .s_group_count(s_group_count),
        .s_group_size (s_group_size),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_value    (f_value),
        .out_grp      (f_grp),
        .out_ec       (f_ec),
        .out_cs       (f_cs),
        .out_seg_end  (f_seg_end)
    );

    // Queue entry layout, from the top: value, group, offset, length, end flag.
    assign q_in = {f_value, f_grp, f_ec, f_cs, f_seg_end};

    iis_queue #(
        .DATA_W(ENT_W),
        .DEPTH (IIS_QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (q_in),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_out),
        .status   (q_stat)
    );

    // Back end: base accumulation and result register.
    iis_back #(
        .INDEX_WIDTH(INDEX_WIDTH),
        .GRP_W      (GRP_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_value       (q_out[ENT_W-1 -: IIS_VALUE_W]),
        .in_grp         (q_out[2*IW+GRP_W -: GRP_W]),
        .in_ec          (q_out[2*IW -: IW]),
        .in_cs          (q_out[IW -: IW]),
        .in_seg_end     (q_out[0]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_position(m_dest_position),
        .m_moved_value  (m_moved_value),
        .m_segment_end  (m_segment_end)
    );

    // The queue can never report full and empty at once.
    `IIS_ASSERT(a_q_flags, aclk, aresetn, !(q_stat.full && q_stat.empty))
    // With one pop per cycle a full queue cannot be empty in the cycle after.
    `IIS_ASSERT(a_q_drain, aclk, aresetn, q_stat.full |=> !q_stat.empty)
    // Reset empties the result register.
    `IIS_ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_valid)

endmodule

[bench/tb_interleaved_index_scatter_core.sv]
// Self-checking testbench for the interleaved index scatter core.
`timescale 1ns / 1ps

module tb_interleaved_index_scatter_core;
    import iis_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ROWS  = 420;
    localparam int WALK_ROWS    = 64;
    localparam int SETTLE_TICKS = 12;
    localparam int REPORT_LIMIT = 10;

    // One input beat as queued for the driver.
    typedef struct packed {
        logic [IIS_VALUE_W-1:0]    row;
        logic [IIS_COUNT_IN_W-1:0] count;
        logic [IIS_SIZE_IN_W-1:0]  size;
    } row_beat_t;

    // One expected output beat.
    typedef struct packed {
        logic [31:0]            dest;
        logic [IIS_VALUE_W-1:0] row;
        logic                   seg_last;
    } placement_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [IIS_VALUE_W-1:0]    s_row_value = '0;
    logic [IIS_COUNT_IN_W-1:0] s_group_count = '0;
    logic [IIS_SIZE_IN_W-1:0]  s_group_size = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [31:0]               m_dest_position;
    logic [IIS_VALUE_W-1:0]    m_moved_value;
    logic                      m_segment_end;

    // Mirror of the block's running state.
    logic [31:0] seg_base = '0;
    logic [16:0] group_pos = '0;
    logic [10:0] elem_pos = '0;

    row_beat_t  queued_rows[$];
    placement_t pending_placements[$];
    row_beat_t  next_row;
    placement_t want;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int hold_gap = 0;
    int fault_count = 0;
    int cycle_count = 0;

    interleaved_index_scatter_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_value     (s_row_value),
        .s_group_count   (s_group_count),
        .s_group_size    (s_group_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dest_position (m_dest_position),
        .m_moved_value   (m_moved_value),
        .m_segment_end   (m_segment_end)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Works out where the next row lands and advances the segment counters.
    function automatic placement_t next_placement(input logic [31:0] row,
                                                  input logic [16:0] count_in,
                                                  input logic [10:0] size_in);
        logic [16:0] cnt;
        logic [10:0] sz;
        logic [16:0] grp;
        logic [10:0] elem;
        logic        elem_last;
        logic        grp_last;
        placement_t  p;
        // Zero means one; anything above the maximum is saturated.
        if (count_in == '0)
            cnt = 17'd1;
        else if (count_in > 17'(IIS_MAX_GROUP_COUNT))
            cnt = 17'(IIS_MAX_GROUP_COUNT);
        else
            cnt = count_in;
        if (size_in == '0)
            sz = 11'd1;
        else if (size_in > 11'(IIS_MAX_GROUP_SIZE))
            sz = 11'(IIS_MAX_GROUP_SIZE);
        else
            sz = size_in;
        // A counter left beyond a shrunken segment sits at its last position.
        grp  = (group_pos > cnt - 17'd1) ? cnt - 17'd1 : group_pos;
        elem = (elem_pos > sz - 11'd1) ? sz - 11'd1 : elem_pos;
        p.dest = seg_base + 32'(grp) + 32'(elem) * 32'(cnt);
        p.row  = row;
        elem_last  = (elem == sz - 11'd1);
        grp_last   = (grp == cnt - 17'd1);
        p.seg_last = elem_last && grp_last;
        if (p.seg_last) begin
            seg_base  = seg_base + 32'(cnt) * 32'(sz);
            group_pos = '0;
            elem_pos  = '0;
        end else if (elem_last) begin
            elem_pos  = '0;
            group_pos = grp + 17'd1;
        end else begin
            elem_pos  = elem + 11'd1;
            group_pos = grp;
        end
        return p;
    endfunction

    // Wait drawn before each beat; the walk and a share of beats run without gaps.
    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_row(input logic [31:0] row, input logic [16:0] cnt,
                             input logic [10:0] sz);
        row_beat_t b;
        b.row   = row;
        b.count = cnt;
        b.size  = sz;
        queued_rows = {queued_rows, b};
    endtask

    // Holds the sender back until every queued beat has gone and every result has come.
    task automatic drain();
        while (queued_rows.size() != 0 || s_valid || pending_placements.size() != 0)
            @(posedge aclk);
    endtask

    // Sampling at the rising edge: predict on input beats, check output beats.
    always @(posedge aclk) begin
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                pending_placements = {pending_placements,
                    next_placement(s_row_value, s_group_count, s_group_size)};
            end
            if (m_valid && m_ready) begin
                out_taken = 1'b1;
                if (pending_placements.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("Unexpected beat: dest=%h value=%h end=%b",
                                 m_dest_position, m_moved_value, m_segment_end);
                end else begin
                    want = pending_placements.pop_front();
                    if (m_dest_position !== want.dest || m_moved_value !== want.row ||
                        m_segment_end !== want.seg_last) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display({"Mismatch: dest exp=%h got=%h value exp=%h got=%h",
                                      " end exp=%b got=%b"},
                                     want.dest, m_dest_position, want.row, m_moved_value,
                                     want.seg_last, m_segment_end);
                    end
                end
            end
        end
    end

    // Input driver: takes beats from the queue, with a random wait before each.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken)
                send_gap = draw_wait();
            if (!s_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (queued_rows.size() != 0) begin
                    next_row = queued_rows.pop_front();
                    s_row_value   <= next_row.row;
                    s_group_count <= next_row.count;
                    s_group_size  <= next_row.size;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure: a random stall is counted only while a result is offered.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken)
                hold_gap = draw_wait();
            if (hold_gap > 0) begin
                m_ready <= 1'b0;
                if (m_valid)
                    hold_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int pick;
        int seg_cnt;
        int seg_size;
        int seg_len;
        int random_rows;
        int k;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats: extreme values, zero and oversized count and size,
        // counters stranded by a shrinking segment, and short whole segments.
        queue_row(32'h0000_0000, 17'd1, 11'd1);
        queue_row(32'hFFFF_FFFF, 17'd0, 11'd0);
        queue_row(32'h0000_0001, 17'h1FFFF, 11'h7FF);
        queue_row(32'h8000_0000, 17'd3, 11'd1);
        queue_row(32'h7FFF_FFFF, 17'd3, 11'd1);
        queue_row(32'h0000_0000, 17'd2, 11'd4);
        queue_row(32'h1234_5678, 17'd2, 11'd4);
        queue_row(32'hA5A5_A5A5, 17'd2, 11'd4);
        for (k = 0; k < 6; k++)
            queue_row(pick_value(), 17'd3, 11'd2);
        queue_row(32'hFFFF_FFFF, 17'd65536, 11'd1024);
        queue_row(32'h5A5A_5A5A, 17'd1, 11'd1024);
        queue_row(32'h0000_0000, 17'd1, 11'd1);
        queue_row(32'hDEAD_BEEF, 17'd2, 11'd1025);
        queue_row(32'h0000_0002, 17'd65537, 11'd1);
        queue_row(32'h0000_0003, 17'd1, 11'd1);
        queue_row(32'hFFFF_FFFE, 17'd4, 11'd0);
        queue_row(32'h0000_0000, 17'd1, 11'd1);
        drain();

        // A walk along the first group of the largest segment, without gaps,
        // so the element offset grows in steps of the largest count.
        quiet = 1'b1;
        for (k = 0; k < WALK_ROWS; k++)
            queue_row($urandom, 17'(IIS_MAX_GROUP_COUNT), 11'(IIS_MAX_GROUP_SIZE));
        drain();
        quiet = 1'b0;

        // Random part: mostly whole small segments, some cut short, some lone
        // beats with arbitrary raw count and size.
        random_rows = 0;
        while (random_rows < RANDOM_ROWS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                seg_cnt  = $urandom_range(1, 6);
                seg_size = $urandom_range(1, 6);
                seg_len  = seg_cnt * seg_size;
                if (pick >= 5)
                    seg_len = $urandom_range(1, seg_len);
                for (k = 0; k < seg_len; k++) begin
                    queue_row(pick_value(),
                              (seg_cnt == 1 && $urandom_range(0, 1)) ? 17'd0 : 17'(seg_cnt),
                              (seg_size == 1 && $urandom_range(0, 1)) ? 11'd0 : 11'(seg_size));
                    random_rows++;
                end
            end else begin
                queue_row(pick_value(), 17'($urandom_range(0, 131071)),
                          11'($urandom_range(0, 2047)));
                random_rows++;
            end
        end
        drain();
        repeat (SETTLE_TICKS) @(posedge aclk);

        fault_count += pending_placements.size();
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/iis_pkg.sv
design/iis_queue.sv
design/iis_front.sv
design/iis_back.sv
design/interleaved_index_scatter_core.sv
bench/tb_interleaved_index_scatter_core.sv
